@@ src/rfpw_pkg.sv @@
// ----------------------------------------------------------------------------
// rfpw_pkg
// Shared types and constants of the rectangle fill pixel writer: field widths,
// result kinds, operation codes, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rfpw_pkg;

   // Coordinate width; every coordinate-derived width follows from it.
   localparam int COORD_BITS   = 16;
   localparam int STOP_BITS    = COORD_BITS + 1;
   localparam int PITCH_BITS   = 18;
   localparam int OFFSET_BITS  = 34;
   localparam int XBYTES_BITS  = COORD_BITS + 2;
   localparam int PROD_BITS    = COORD_BITS + PITCH_BITS;
   localparam int COLOR_BITS   = 32;
   localparam int BE_BITS      = 4;
   localparam int KIND_BITS    = 2;

   // Configuration port.
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;

   // Stream payload widths.
   localparam int REQ_DATA_BITS = 4 * COORD_BITS + COLOR_BITS;
   localparam int RSP_PAYLOAD   = OFFSET_BITS + COLOR_BITS + BE_BITS;
   localparam int RSP_DATA_BITS = ((RSP_PAYLOAD + 7) / 8) * 8;

   localparam logic [BE_BITS-1:0]    BE_FOUR_BYTES  = 4'hF;
   localparam logic [BE_BITS-1:0]    BE_THREE_BYTES = 4'h7;
   localparam logic [XBYTES_BITS-1:0] STEP_FOUR     = XBYTES_BITS'(4);
   localparam logic [XBYTES_BITS-1:0] STEP_THREE    = XBYTES_BITS'(3);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_WRITE  = 2'd0,
      KIND_REJECT = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      REG_SCREEN_WIDTH  = 3'd0,
      REG_SCREEN_HEIGHT = 3'd1,
      REG_ROW_PITCH     = 3'd2,
      REG_FOUR_BYTE     = 3'd3,
      REG_ENABLED       = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] screen_width;
      logic [COORD_BITS-1:0] screen_height;
      logic [PITCH_BITS-1:0] row_pitch;
      logic                  four_byte_pixels;
      logic                  enabled;
   } cfg_type;

endpackage

`default_nettype wire

@@ src/rect_fill_pixel_writer.sv @@
// ----------------------------------------------------------------------------
// rect_fill_pixel_writer
// Rectangle fill engine for a linear framebuffer: clips a rectangle to the
// screen and then issues one pixel write for each step item.
// ----------------------------------------------------------------------------
// Usage: configure the screen size, row pitch, pixel format and enable bit
// through the csr_ port while no item is in flight. Send a start item
// (req_tuser = start) carrying origin, size and colour; it yields a single
// reject or empty-done item, or nothing when the clipped area is stored.
// Each following step item (req_tuser = step) yields the next pixel write in
// row-major order, with rsp_tlast set on the final write of the fill. A step
// while no fill is active yields nothing; a start always cancels a fill.
// rsp_tvalid rises once a result is registered, so a result passes through
// one input register, which also holds the origin_y times row_pitch product,
// and one result register. Throughput is one item per cycle while the receiver
// takes each result; the loop that sets it is the fill state update, a single
// add-and-compare of the column and row counters.
// When the receiver stalls, the result register holds its item and items that
// give no result still pass through the input register; once the input
// register holds an item with a result, req_tready falls until the waiting
// result is taken. Reset clears the configuration (four-byte pixels,
// disabled), ends any fill in progress and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_fill_pixel_writer
   import rfpw_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Request stream.
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // tdata from bit 0: origin_x, origin_y, rect_width, rect_height, fill_color
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // tuser: opcode
   input  wire logic                     req_tuser,
   // Result stream.
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // tdata from bit 0: byte_offset, write_data, byte_enables, zero padding
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   // tuser: kind
   output logic      [KIND_BITS-1:0]     rsp_tuser,
   output logic                          rsp_tlast,
   // Configuration port.
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   cfg_type cfg;

   rfpw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ------------------------------------------------------------------
   // Input register. The row product and the column byte offset of the
   // origin are formed here so that the fill stage only has to add.
   // ------------------------------------------------------------------
   logic                   in_valid_ff;
   op_type                 in_op_ff;
   logic [COORD_BITS-1:0]  in_x_ff;
   logic [COORD_BITS-1:0]  in_y_ff;
   logic [COORD_BITS-1:0]  in_w_ff;
   logic [COORD_BITS-1:0]  in_h_ff;
   logic [COLOR_BITS-1:0]  in_color_ff;
   logic [OFFSET_BITS-1:0] in_row_offset_ff;
   logic [XBYTES_BITS-1:0] in_x3_ff;

   logic [COORD_BITS-1:0]  req_x;
   logic [COORD_BITS-1:0]  req_y;
   logic [PROD_BITS-1:0]   req_prod;
   logic                   req_fire;
   logic                   stage_fire;

   assign req_x    = req_tdata[COORD_BITS-1:0];
   assign req_y    = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign req_prod = PROD_BITS'(req_y) * PROD_BITS'(cfg.row_pitch);
   assign req_fire = req_tvalid && req_tready;

   // The input register may refill in the same cycle that it drains.
   assign req_tready = !in_valid_ff || stage_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (stage_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff         <= op_type'(req_tuser);
         in_x_ff          <= req_x;
         in_y_ff          <= req_y;
         in_w_ff          <= req_tdata[3*COORD_BITS-1:2*COORD_BITS];
         in_h_ff          <= req_tdata[4*COORD_BITS-1:3*COORD_BITS];
         in_color_ff      <= req_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
         in_row_offset_ff <= OFFSET_BITS'(req_prod);
         in_x3_ff         <= {2'b00, req_x} + {1'b0, req_x, 1'b0};
      end
   end

   // ------------------------------------------------------------------
   // Fill state.
   // ------------------------------------------------------------------
   logic                   busy_ff,         busy_in;
   logic [COORD_BITS-1:0]  cur_column_ff,   cur_column_in;
   logic [COORD_BITS-1:0]  cur_row_ff,      cur_row_in;
   logic [COORD_BITS-1:0]  first_column_ff, first_column_in;
   logic [XBYTES_BITS-1:0] first_x3_ff,     first_x3_in;
   logic [STOP_BITS-1:0]   stop_column_ff,  stop_column_in;
   logic [STOP_BITS-1:0]   stop_row_ff,     stop_row_in;
   logic [OFFSET_BITS-1:0] row_offset_ff,   row_offset_in;
   logic [OFFSET_BITS-1:0] pixel_offset_ff, pixel_offset_in;
   logic [COLOR_BITS-1:0]  held_color_ff,   held_color_in;

   // Result register.
   logic                   out_valid_ff;
   kind_type               out_kind_ff,     out_kind_in;
   logic [OFFSET_BITS-1:0] out_offset_ff,   out_offset_in;
   logic [COLOR_BITS-1:0]  out_data_ff,     out_data_in;
   logic [BE_BITS-1:0]     out_be_ff,       out_be_in;
   logic                   out_last_ff,     out_last_in;

   // Start decode.
   logic [STOP_BITS-1:0]   end_x;
   logic [STOP_BITS-1:0]   end_y;
   logic [STOP_BITS-1:0]   clip_x;
   logic [STOP_BITS-1:0]   clip_y;
   logic                   start_reject;
   logic                   start_empty;

   // Step decode.
   logic [COORD_BITS-1:0]  column_inc;
   logic [COORD_BITS-1:0]  row_inc;
   logic                   column_wrap;
   logic                   row_done;
   logic                   step_last;
   logic [XBYTES_BITS-1:0] pixel_step;
   logic [XBYTES_BITS-1:0] first_bytes;
   logic [XBYTES_BITS-1:0] origin_bytes;
   logic [OFFSET_BITS-1:0] next_row_offset;

   logic                   has_result;

   assign end_x  = {1'b0, in_x_ff} + {1'b0, in_w_ff};
   assign end_y  = {1'b0, in_y_ff} + {1'b0, in_h_ff};
   assign clip_x = (end_x > {1'b0, cfg.screen_width})  ? {1'b0, cfg.screen_width}  : end_x;
   assign clip_y = (end_y > {1'b0, cfg.screen_height}) ? {1'b0, cfg.screen_height} : end_y;

   assign start_reject = !cfg.enabled || (in_x_ff >= cfg.screen_width)
                         || (in_y_ff >= cfg.screen_height);
   assign start_empty  = (clip_x <= {1'b0, in_x_ff}) || (clip_y <= {1'b0, in_y_ff});

   assign pixel_step   = cfg.four_byte_pixels ? STEP_FOUR : STEP_THREE;
   assign first_bytes  = cfg.four_byte_pixels ? {first_column_ff, 2'b00} : first_x3_ff;
   assign origin_bytes = cfg.four_byte_pixels ? {in_x_ff, 2'b00} : in_x3_ff;

   assign column_inc  = cur_column_ff + COORD_BITS'(1);
   assign row_inc     = cur_row_ff + COORD_BITS'(1);
   assign column_wrap = (column_inc == '0) || ({1'b0, column_inc} >= stop_column_ff);
   assign row_done    = (row_inc == '0) || ({1'b0, row_inc} >= stop_row_ff);
   assign step_last   = column_wrap && row_done;
   assign next_row_offset = row_offset_ff + OFFSET_BITS'(cfg.row_pitch);

   // A start that is stored yields nothing, and so does a step while idle.
   assign has_result = (in_op_ff == OP_START) ? (start_reject || start_empty) : busy_ff;

   // The item in the input register is consumed unless its result would
   // overwrite a result that the receiver has not yet taken.
   assign stage_fire = in_valid_ff && (!has_result || !out_valid_ff || rsp_tready);

   always_comb begin
      busy_in         = busy_ff;
      cur_column_in   = cur_column_ff;
      cur_row_in      = cur_row_ff;
      first_column_in = first_column_ff;
      first_x3_in     = first_x3_ff;
      stop_column_in  = stop_column_ff;
      stop_row_in     = stop_row_ff;
      row_offset_in   = row_offset_ff;
      pixel_offset_in = pixel_offset_ff;
      held_color_in   = held_color_ff;

      out_kind_in   = KIND_WRITE;
      out_offset_in = '0;
      out_data_in   = '0;
      out_be_in     = '0;
      out_last_in   = 1'b1;

      if (stage_fire) begin
         unique case (in_op_ff)
            OP_START: begin
               // Any start cancels the fill in progress.
               busy_in = 1'b0;
               if (start_reject) begin
                  out_kind_in = KIND_REJECT;
               end else if (start_empty) begin
                  out_kind_in = KIND_EMPTY;
               end else begin
                  busy_in         = 1'b1;
                  cur_column_in   = in_x_ff;
                  cur_row_in      = in_y_ff;
                  first_column_in = in_x_ff;
                  first_x3_in     = in_x3_ff;
                  stop_column_in  = clip_x;
                  stop_row_in     = clip_y;
                  held_color_in   = in_color_ff;
                  row_offset_in   = in_row_offset_ff;
                  pixel_offset_in = in_row_offset_ff + OFFSET_BITS'(origin_bytes);
               end
            end
            OP_STEP: begin
               if (busy_ff) begin
                  out_kind_in   = KIND_WRITE;
                  out_offset_in = pixel_offset_ff;
                  out_last_in   = step_last;
                  if (cfg.four_byte_pixels) begin
                     out_data_in = held_color_ff;
                     out_be_in   = BE_FOUR_BYTES;
                  end else begin
                     // Three-byte pixels leave the top byte clear.
                     out_data_in = {8'h00, held_color_ff[23:0]};
                     out_be_in   = BE_THREE_BYTES;
                  end
                  if (!column_wrap) begin
                     cur_column_in   = column_inc;
                     pixel_offset_in = pixel_offset_ff + OFFSET_BITS'(pixel_step);
                  end else begin
                     cur_column_in   = first_column_ff;
                     cur_row_in      = row_inc;
                     row_offset_in   = next_row_offset;
                     pixel_offset_in = next_row_offset + OFFSET_BITS'(first_bytes);
                     if (row_done) begin
                        busy_in = 1'b0;
                     end
                  end
               end
            end
            default: begin
               busy_in = busy_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_column_ff   <= cur_column_in;
      cur_row_ff      <= cur_row_in;
      first_column_ff <= first_column_in;
      first_x3_ff     <= first_x3_in;
      stop_column_ff  <= stop_column_in;
      stop_row_ff     <= stop_row_in;
      row_offset_ff   <= row_offset_in;
      pixel_offset_ff <= pixel_offset_in;
      held_color_ff   <= held_color_in;
   end

   // ------------------------------------------------------------------
   // Result register.
   // ------------------------------------------------------------------
   logic out_load;

   assign out_load = stage_fire && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff   <= out_kind_in;
         out_offset_ff <= out_offset_in;
         out_data_ff   <= out_data_in;
         out_be_ff     <= out_be_in;
         out_last_ff   <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({out_be_ff, out_data_ff, out_offset_ff});

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_cursor_in_area: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_column_ff >= first_column_ff)
                  && ({1'b0, cur_column_ff} < stop_column_ff)
                  && ({1'b0, cur_row_ff} < stop_row_ff))
      else $error("fill cursor outside the clipped area");

   a_busy_ends: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(stage_fire && ((in_op_ff == OP_START) || step_last)))
      else $error("fill ended without a start or a last write");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_kind_ff != KIND_WRITE)) |-> out_last_ff)
      else $error("reject or empty-done item without last");

   a_write_enables: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_kind_ff == KIND_WRITE))
         |-> ((out_be_ff == BE_FOUR_BYTES) || (out_be_ff == BE_THREE_BYTES)))
      else $error("pixel write with bad byte enables");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !out_load)
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

@@ src/rfpw_csr.sv @@
// ----------------------------------------------------------------------------
// rfpw_csr
// Configuration registers of the fill engine behind a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module rfpw_csr
   import rfpw_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready,
   output cfg_type                       cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_strobe;

   assign csr_pready   = 1'b1;
   assign index        = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign write_strobe = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         unique case (index)
            REG_SCREEN_WIDTH:  cfg_in.screen_width     = csr_pwdata[COORD_BITS-1:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height    = csr_pwdata[COORD_BITS-1:0];
            REG_ROW_PITCH:     cfg_in.row_pitch        = csr_pwdata[PITCH_BITS-1:0];
            REG_FOUR_BYTE:     cfg_in.four_byte_pixels = csr_pwdata[0];
            REG_ENABLED:       cfg_in.enabled          = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width     <= '0;
         cfg_ff.screen_height    <= '0;
         cfg_ff.row_pitch        <= '0;
         cfg_ff.four_byte_pixels <= 1'b1;
         cfg_ff.enabled          <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_SCREEN_WIDTH:  csr_prdata = CSR_DATA_BITS'(cfg_ff.screen_width);
         REG_SCREEN_HEIGHT: csr_prdata = CSR_DATA_BITS'(cfg_ff.screen_height);
         REG_ROW_PITCH:     csr_prdata = CSR_DATA_BITS'(cfg_ff.row_pitch);
         REG_FOUR_BYTE:     csr_prdata = CSR_DATA_BITS'(cfg_ff.four_byte_pixels);
         REG_ENABLED:       csr_prdata = CSR_DATA_BITS'(cfg_ff.enabled);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire
